@@ hdl/fcam_pkg.sv @@
// Shared types, constants and tables for the fly camera block.
package fcam_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN = 24;
  localparam int CORDIC_RUN = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int IDX_W = 5;

  localparam logic [2:0] OP_LOOK  = 3'd0;
  localparam logic [2:0] OP_FWD   = 3'd1;
  localparam logic [2:0] OP_BACK  = 3'd2;
  localparam logic [2:0] OP_RIGHT = 3'd3;
  localparam logic [2:0] OP_LEFT  = 3'd4;

  localparam logic [7:0] REG_SENS  = 8'd0;
  localparam logic [7:0] REG_SPEED = 8'd1;

  localparam logic [3:0] ACT_NONE  = 4'd0;
  localparam logic [3:0] ACT_LATCH = 4'd1;
  localparam logic [3:0] ACT_ANGX  = 4'd2;
  localparam logic [3:0] ACT_ANGY  = 4'd3;
  localparam logic [3:0] ACT_MOD   = 4'd4;
  localparam logic [3:0] ACT_YAW   = 4'd5;
  localparam logic [3:0] ACT_CINIT = 4'd6;
  localparam logic [3:0] ACT_CSTEP = 4'd7;
  localparam logic [3:0] ACT_CSAVE = 4'd8;
  localparam logic [3:0] ACT_MULX  = 4'd9;
  localparam logic [3:0] ACT_MULZ  = 4'd10;
  localparam logic [3:0] ACT_RNDZ  = 4'd11;
  localparam logic [3:0] ACT_SIDE  = 4'd12;
  localparam logic [3:0] ACT_MOVE  = 4'd13;
  localparam logic [3:0] ACT_OUT   = 4'd14;

  localparam logic [IDX_W-1:0] MOD_TOP = 5'd10;

  localparam logic signed [26:0] YAW_SPAN   = 27'sd46080;
  localparam logic signed [26:0] YAW_HALF   = 27'sd23040;
  localparam logic signed [26:0] YAW_LIFT   = 27'sd23592960;
  localparam logic signed [15:0] QUARTER    = 16'sd11520;
  localparam logic signed [15:0] HALF16     = 16'sd23040;
  localparam logic signed [25:0] PITCH_LIM  = 26'sd11392;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [15:0] YAW_RESET  = -16'sd11520;
  localparam logic signed [15:0] PTR_RESET  = 16'sd450;
  localparam logic signed [15:0] DIR_NEG1   = -16'sd16384;
  localparam logic [15:0] SENS_RESET  = 16'd6554;
  localparam logic [15:0] SPEED_RESET = 16'd192;

  typedef struct packed {
    logic [3:0]       act;
    logic             sel;
    logic             add;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  function automatic logic [21:0] atan_deg16(input logic [IDX_W-1:0] i);
    logic [21:0] r;
    case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/fcam_dp.sv @@
// Datapath: camera state, shared CORDIC unit, multipliers and output register.
module fcam_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  fcam_pkg::cmd_t cmd,
  input  logic [31:0]    in_tdata,
  input  logic           cfg_valid,
  input  logic [7:0]     cfg_index,
  input  logic [15:0]    cfg_data,
  output logic [175:0]   out_data
);

  function automatic logic signed [15:0] q46(input logic signed [67:0] v);
    logic signed [67:0] r;
    logic signed [21:0] t;
    r = v + (68'sd1 <<< 45);
    t = r[67:46];
    if (t > 22'sd16384) return 16'sd16384;
    if (t < -22'sd16384) return -16'sd16384;
    return t[15:0];
  endfunction

  function automatic logic signed [15:0] q16(input logic signed [33:0] v);
    logic signed [33:0] r;
    logic signed [17:0] t;
    r = v + 34'sd32768;
    t = r[33:16];
    if (t > 18'sd16384) return 16'sd16384;
    if (t < -18'sd16384) return -16'sd16384;
    return t[15:0];
  endfunction

  logic [15:0]        sens_r, speed_r;
  logic signed [15:0] px_r, py_r, lastx_r, lasty_r, yaw_r;
  logic signed [14:0] pitch_r;
  logic signed [31:0] pos_r [3];
  logic signed [15:0] dir_r [3];
  logic signed [15:0] vec_r [3];
  logic signed [24:0] dy_r, dp_r;
  logic signed [26:0] v_r;
  logic signed [33:0] x_r, y_r, cy_r, sy_r, cp_r, sp_r;
  logic signed [25:0] z_r;
  logic               neg_r;
  logic signed [67:0] prod_r;
  logic [175:0]       out_r;

  logic signed [16:0] dxp, dyp, sens_s;
  logic signed [33:0] mx, my, rx, ry;
  logic signed [25:0] psum;
  logic signed [14:0] pitch_new;
  logic signed [26:0] mc;
  logic signed [15:0] ang, af;
  logic signed [33:0] sx, sy;
  logic signed [25:0] at;
  logic signed [33:0] cval, sval;
  logic signed [15:0] comp;
  logic signed [32:0] sm, rs;
  logic signed [26:0] st;
  logic signed [33:0] pcur, psum2;
  logic signed [31:0] pnew;
  logic [1:0]         k;

  always_comb begin
    dxp = 17'(px_r) - 17'(lastx_r);
    dyp = 17'(lasty_r) - 17'(py_r);
    sens_s = $signed({1'b0, sens_r});
    mx = 34'(dxp) * 34'(sens_s);
    my = 34'(dyp) * 34'(sens_s);
    rx = mx + 34'sd256;
    ry = my + 34'sd256;
    psum = 26'(pitch_r) + 26'(dp_r);
    if (psum > fcam_pkg::PITCH_LIM) pitch_new = 15'(fcam_pkg::PITCH_LIM);
    else if (psum < -fcam_pkg::PITCH_LIM) pitch_new = 15'(-fcam_pkg::PITCH_LIM);
    else pitch_new = psum[14:0];
    mc = fcam_pkg::YAW_SPAN <<< cmd.idx;
    ang = cmd.sel ? 16'(pitch_r) : yaw_r;
    if (ang > fcam_pkg::QUARTER) af = ang - fcam_pkg::HALF16;
    else if (ang < -fcam_pkg::QUARTER) af = ang + fcam_pkg::HALF16;
    else af = ang;
    sx = y_r >>> cmd.idx;
    sy = x_r >>> cmd.idx;
    at = $signed({4'b0, fcam_pkg::atan_deg16(cmd.idx)});
    cval = neg_r ? -x_r : x_r;
    sval = neg_r ? -y_r : y_r;
    k = cmd.idx[1:0];
    case (k)
      2'd0:    comp = cmd.sel ? vec_r[0] : dir_r[0];
      2'd1:    comp = cmd.sel ? vec_r[1] : dir_r[1];
      default: comp = cmd.sel ? vec_r[2] : dir_r[2];
    endcase
    sm = 33'(comp) * 33'($signed({1'b0, speed_r}));
    rs = sm + 33'sd32;
    st = rs[32:6];
    case (k)
      2'd0:    pcur = 34'(pos_r[0]);
      2'd1:    pcur = 34'(pos_r[1]);
      default: pcur = 34'(pos_r[2]);
    endcase
    psum2 = cmd.add ? pcur + 34'(st) : pcur - 34'(st);
    if (psum2 > 34'sd2147483647) pnew = 32'sh7FFFFFFF;
    else if (psum2 < -34'sd2147483648) pnew = 32'sh80000000;
    else pnew = psum2[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r  <= fcam_pkg::SENS_RESET;
      speed_r <= fcam_pkg::SPEED_RESET;
      lastx_r <= fcam_pkg::PTR_RESET;
      lasty_r <= fcam_pkg::PTR_RESET;
      yaw_r   <= fcam_pkg::YAW_RESET;
      pitch_r <= '0;
      for (int i = 0; i < 3; i++) pos_r[i] <= '0;
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= fcam_pkg::DIR_NEG1;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == fcam_pkg::REG_SENS) sens_r <= cfg_data;
        else if (cfg_index == fcam_pkg::REG_SPEED) speed_r <= cfg_data;
      end
      case (cmd.act)
        fcam_pkg::ACT_ANGY: begin
          lastx_r <= px_r;
          lasty_r <= py_r;
        end
        fcam_pkg::ACT_MOD: begin
          if (cmd.idx == fcam_pkg::MOD_TOP) pitch_r <= pitch_new;
        end
        fcam_pkg::ACT_YAW: yaw_r <= 16'(v_r - fcam_pkg::YAW_HALF);
        fcam_pkg::ACT_MULZ: dir_r[0] <= q46(prod_r);
        fcam_pkg::ACT_RNDZ: begin
          dir_r[2] <= q46(prod_r);
          dir_r[1] <= q16(sp_r);
        end
        fcam_pkg::ACT_MOVE: begin
          case (k)
            2'd0:    pos_r[0] <= pnew;
            2'd1:    pos_r[1] <= pnew;
            default: pos_r[2] <= pnew;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.act)
      fcam_pkg::ACT_LATCH: begin
        px_r <= in_tdata[15:0];
        py_r <= in_tdata[31:16];
      end
      fcam_pkg::ACT_ANGX: dy_r <= rx[33:9];
      fcam_pkg::ACT_ANGY: begin
        dp_r <= ry[33:9];
        v_r  <= 27'(yaw_r) + 27'(dy_r) + fcam_pkg::YAW_HALF;
      end
      fcam_pkg::ACT_MOD: begin
        if (cmd.idx == fcam_pkg::MOD_TOP) begin
          if (v_r < 27'sd0) v_r <= v_r + fcam_pkg::YAW_LIFT;
        end else if (v_r >= mc) begin
          v_r <= v_r - mc;
        end
      end
      fcam_pkg::ACT_CINIT: begin
        x_r   <= fcam_pkg::CORDIC_START;
        y_r   <= '0;
        z_r   <= 26'(af) <<< 9;
        neg_r <= (ang > fcam_pkg::QUARTER) || (ang < -fcam_pkg::QUARTER);
      end
      fcam_pkg::ACT_CSTEP: begin
        if (!z_r[25]) begin
          x_r <= x_r - sx;
          y_r <= y_r + sy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + sx;
          y_r <= y_r - sy;
          z_r <= z_r + at;
        end
      end
      fcam_pkg::ACT_CSAVE: begin
        if (cmd.sel) begin
          cp_r <= cval;
          sp_r <= sval;
        end else begin
          cy_r <= cval;
          sy_r <= sval;
        end
      end
      fcam_pkg::ACT_MULX: prod_r <= 68'(cy_r) * 68'(cp_r);
      fcam_pkg::ACT_MULZ: prod_r <= 68'(sy_r) * 68'(cp_r);
      fcam_pkg::ACT_SIDE: begin
        vec_r[0] <= -q16(sy_r);
        vec_r[1] <= '0;
        vec_r[2] <= q16(cy_r);
      end
      fcam_pkg::ACT_OUT: begin
        out_r <= {1'b0, pitch_r, yaw_r, dir_r[2], dir_r[1], dir_r[0],
                  pos_r[2], pos_r[1], pos_r[0]};
      end
      default: ;
    endcase
  end

  assign out_data = out_r;

endmodule

@@ hdl/fcam_ctrl.sv @@
// Controller: sequences each item through the datapath and runs the handshakes.
module fcam_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [2:0]     in_tuser,
  output logic           out_tvalid,
  input  logic           out_tready,
  output fcam_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ANGX  = 4'd1;
  localparam logic [3:0] S_ANGY  = 4'd2;
  localparam logic [3:0] S_MOD   = 4'd3;
  localparam logic [3:0] S_YAW   = 4'd4;
  localparam logic [3:0] S_CINIT = 4'd5;
  localparam logic [3:0] S_CSTEP = 4'd6;
  localparam logic [3:0] S_CSAVE = 4'd7;
  localparam logic [3:0] S_MULX  = 4'd8;
  localparam logic [3:0] S_MULZ  = 4'd9;
  localparam logic [3:0] S_RNDZ  = 4'd10;
  localparam logic [3:0] S_SIDE  = 4'd11;
  localparam logic [3:0] S_MOVE  = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  localparam logic [fcam_pkg::IDX_W-1:0] LAST_STEP =
    fcam_pkg::IDX_W'(fcam_pkg::CORDIC_RUN - 1);
  localparam logic [fcam_pkg::IDX_W-1:0] CTR_ONE = fcam_pkg::IDX_W'(1);

  logic [3:0]                   state_r, state_nxt;
  logic [fcam_pkg::IDX_W-1:0]   ctr_r, ctr_nxt;
  logic [2:0]                   op_r, op_nxt;
  logic                         sel_r, sel_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         side_op;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign side_op    = (op_r == fcam_pkg::OP_RIGHT) || (op_r == fcam_pkg::OP_LEFT);

  always_comb begin
    state_nxt = state_r;
    ctr_nxt = ctr_r;
    op_nxt = op_r;
    sel_nxt = sel_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.act = fcam_pkg::ACT_NONE;
    cmd.sel = sel_r;
    cmd.add = (op_r == fcam_pkg::OP_FWD) || (op_r == fcam_pkg::OP_RIGHT);
    cmd.idx = ctr_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.act = fcam_pkg::ACT_LATCH;
          op_nxt = in_tuser;
          sel_nxt = 1'b0;
          ctr_nxt = '0;
          case (in_tuser)
            fcam_pkg::OP_LOOK: state_nxt = S_ANGX;
            fcam_pkg::OP_FWD, fcam_pkg::OP_BACK: state_nxt = S_MOVE;
            fcam_pkg::OP_RIGHT, fcam_pkg::OP_LEFT: state_nxt = S_CINIT;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_ANGX: begin
        cmd.act = fcam_pkg::ACT_ANGX;
        state_nxt = S_ANGY;
      end
      S_ANGY: begin
        cmd.act = fcam_pkg::ACT_ANGY;
        ctr_nxt = fcam_pkg::MOD_TOP;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd.act = fcam_pkg::ACT_MOD;
        if (ctr_r == '0) state_nxt = S_YAW;
        else ctr_nxt = ctr_r - CTR_ONE;
      end
      S_YAW: begin
        cmd.act = fcam_pkg::ACT_YAW;
        state_nxt = S_CINIT;
      end
      S_CINIT: begin
        cmd.act = fcam_pkg::ACT_CINIT;
        ctr_nxt = '0;
        state_nxt = S_CSTEP;
      end
      S_CSTEP: begin
        cmd.act = fcam_pkg::ACT_CSTEP;
        if (ctr_r == LAST_STEP) state_nxt = S_CSAVE;
        else ctr_nxt = ctr_r + CTR_ONE;
      end
      S_CSAVE: begin
        cmd.act = fcam_pkg::ACT_CSAVE;
        if (op_r != fcam_pkg::OP_LOOK) begin
          state_nxt = S_SIDE;
        end else if (!sel_r) begin
          sel_nxt = 1'b1;
          state_nxt = S_CINIT;
        end else begin
          state_nxt = S_MULX;
        end
      end
      S_MULX: begin
        cmd.act = fcam_pkg::ACT_MULX;
        state_nxt = S_MULZ;
      end
      S_MULZ: begin
        cmd.act = fcam_pkg::ACT_MULZ;
        state_nxt = S_RNDZ;
      end
      S_RNDZ: begin
        cmd.act = fcam_pkg::ACT_RNDZ;
        state_nxt = S_DONE;
      end
      S_SIDE: begin
        cmd.act = fcam_pkg::ACT_SIDE;
        ctr_nxt = '0;
        state_nxt = S_MOVE;
      end
      S_MOVE: begin
        cmd.act = fcam_pkg::ACT_MOVE;
        cmd.sel = side_op;
        if (ctr_r == 5'd2) state_nxt = S_DONE;
        else ctr_nxt = ctr_r + CTR_ONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.act = fcam_pkg::ACT_OUT;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ctr_r       <= '0;
      op_r        <= fcam_pkg::OP_LOOK;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctr_r       <= ctr_nxt;
      op_r        <= op_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/fly_camera_orientation_and_move.sv @@
// Fly camera top level: yaw/pitch look and stepwise move with a registered result.
// One item is in work at a time; its result sits in an output register so the next
// item can start while it waits. A look item makes two passes through the single
// iterative CORDIC unit, one micro-rotation per cycle, after the yaw wrap steps and
// before the multiply and round steps (MULX, MULZ, RNDZ). A right or left move makes
// one CORDIC pass before its move steps. A result still waiting in the output
// register stalls the final step. Configuration writes are always ready; the user
// must make them only while no item is in work, which the block does not enforce.
module fly_camera_orientation_and_move (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // pointer_x[15:0], pointer_y[31:16]
  input  logic [2:0]   in_tuser,   // operation[2:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, yaw_out, pitch_out, zero pad
  output logic [175:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  fcam_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  fcam_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  fcam_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_tdata)
  );

endmodule
